// File: hdl/fhpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed hunk pool allocator package
// Shared constants, operation and status codes, and the stack command type.
// ----------------------------------------------------------------------------
`default_nettype none

package fhpa_pkg;

    // Sizes of the free stack and of the returned offsets.
    localparam int FREE_DEPTH   = 256;
    localparam int ADDR_BITS    = 16;
    localparam int IDX_W        = $clog2(FREE_DEPTH);
    localparam int COUNT_W      = $clog2(FREE_DEPTH + 1);

    // Configuration and region widths.
    localparam int HUNK_W       = 13;
    localparam int PAD_W        = HUNK_W + 1;
    localparam int REGION_W     = 17;
    localparam int CFG_IDX_W    = 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_HUNK_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [HUNK_W-1:0]   HUNK_RESET   = 13'd4;
    localparam logic [REGION_W-1:0] REGION_RESET = 17'd0;

    // Operation carried with each input item.
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // Status returned with each result item.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Command from the allocator control to the free stack.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_cmd_t;

endpackage

`default_nettype wire

// File: hdl/fhpa_stack.sv
// ----------------------------------------------------------------------------
// Free offset stack
// LIFO of freed hunk offsets with the top two entries held in registers, so
// that a push or a pop can follow in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fhpa_stack
    import fhpa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire stack_cmd_t           cmd,
    input  wire logic [ADDR_BITS-1:0] push_data,
    output logic [ADDR_BITS-1:0]      top,
    output logic                      empty,
    output logic                      full,
    output logic [COUNT_W-1:0]        count_next
);

    logic [ADDR_BITS-1:0] stack_mem [FREE_DEPTH];
    logic [COUNT_W-1:0]   count_reg;
    logic [ADDR_BITS-1:0] top_reg;
    logic [ADDR_BITS-1:0] below_reg;
    logic [COUNT_W-1:0]   third_pos;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     wr_idx;

    // Status of the stack and its count after the current command.
    assign empty = (count_reg == '0);
    assign full  = (count_reg == COUNT_W'(FREE_DEPTH));
    assign top   = top_reg;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    // The entry that becomes second from the top after a pop.
    assign third_pos = count_reg - COUNT_W'(3);
    assign rd_idx    = third_pos[IDX_W-1:0];
    assign wr_idx    = count_reg[IDX_W-1:0];

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Memory and the two top entries. A push shifts the top down, a pop
    // refills the second entry from memory.
    always_ff @(posedge clk)
    begin
        if (!cmd.clear && cmd.push)
        begin
            stack_mem[wr_idx] <= push_data;
            top_reg           <= push_data;
            below_reg         <= top_reg;
        end
        else if (!cmd.clear && cmd.pop)
        begin
            top_reg   <= below_reg;
            below_reg <= stack_mem[rd_idx];
        end
    end

    // A push is never issued to a full stack.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.push |-> !full)
        else $error("push issued to a full free stack");

    // A pop is never issued to an empty stack.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.pop |-> !empty)
        else $error("pop issued to an empty free stack");

    // Push and pop are exclusive.
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.push && cmd.pop))
        else $error("push and pop issued together");

    // A pushed entry is on top in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && !cmd.clear) |=> (top_reg == $past(push_data)))
        else $error("pushed entry not on top of the stack");

endmodule

`default_nettype wire

// File: hdl/fixed_hunk_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// Fixed hunk pool allocator
// Hands out fixed-size hunk byte offsets from one region, reusing freed
// offsets in last-in first-out order before advancing a bump offset.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while its output is not stalled and
// returns one result item for each, registered in the cycle after acceptance.
// The free stack keeps its top two entries in registers and the rest in a
// 256-entry memory with one registered read, which lets a pop follow a pop in
// the next cycle. The input is held off only while a result waits in the output
// register and the downstream side is not ready. The stack memory needs no
// clearing pass: entries are only read after they were pushed, so the unit is
// ready right after reset. Configuration writes are taken in every cycle.
`default_nettype none

module fixed_hunk_pool_allocator_unit
    import fhpa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [REGION_W-1:0]   cfg_data,
    // Input items.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] hunk_address
    input  wire logic [1:0]            s_tuser,   // [1:0] op
    // Result items.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,   // [15:0] address, [24:16] freed_count
    output logic [1:0]                 m_tuser    // [1:0] status
);

    logic [HUNK_W-1:0]    hunk_reg;
    logic [REGION_W-1:0]  region_reg;
    logic [REGION_W-1:0]  bump_reg;
    logic [REGION_W-1:0]  bump_next;
    logic                 out_valid_reg;
    status_t              status_reg;
    status_t              status_next;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] addr_next;
    logic [COUNT_W-1:0]   freed_reg;

    logic                 accept;
    op_t                  op;
    logic [PAD_W-1:0]     pad;
    logic [REGION_W-1:0]  remaining;
    stack_cmd_t           cmd;
    logic [ADDR_BITS-1:0] stk_top;
    logic                 stk_empty;
    logic                 stk_full;
    logic [COUNT_W-1:0]   stk_count_next;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign op        = op_t'(s_tuser);

    // Padded hunk length and bytes left behind the bump offset.
    assign pad       = ({1'b0, hunk_reg} + PAD_W'(3)) & ~PAD_W'(3);
    assign remaining = (region_reg > bump_reg) ? (region_reg - bump_reg) : '0;

    // Decode of one item.
    always_comb
    begin
        cmd         = '0;
        status_next = ST_OK;
        addr_next   = '0;
        bump_next   = bump_reg;
        case (op)
            OP_ALLOC:
            begin
                if (!stk_empty)
                begin
                    cmd.pop   = accept;
                    addr_next = stk_top;
                end
                else if (remaining < REGION_W'(pad))
                begin
                    status_next = ST_EXHAUSTED;
                end
                else
                begin
                    addr_next = bump_reg[ADDR_BITS-1:0];
                    bump_next = bump_reg + REGION_W'(pad);
                end
            end
            OP_FREE:
            begin
                if (stk_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.push = accept;
                end
            end
            OP_CLEAR:
            begin
                cmd.clear = accept;
                bump_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    fhpa_stack u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_data  (s_tdata[ADDR_BITS-1:0]),
        .top        (stk_top),
        .empty      (stk_empty),
        .full       (stk_full),
        .count_next (stk_count_next)
    );

    // Configuration registers, bump offset and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunk_reg      <= HUNK_RESET;
            region_reg    <= REGION_RESET;
            bump_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HUNK_LENGTH:  hunk_reg   <= cfg_data[HUNK_W-1:0];
                    CFG_REGION_BYTES: region_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (accept)
            begin
                bump_reg      <= bump_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            addr_reg   <= addr_next;
            freed_reg  <= stk_count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(32 - COUNT_W - ADDR_BITS){1'b0}}, freed_reg, addr_reg};

    // A pool reset leaves an empty stack in its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_CLEAR) |=> (m_tvalid && freed_reg == '0))
        else $error("pool reset did not empty the free stack");

    // Exhaustion is only reported when no freed hunk was available.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_reg == ST_EXHAUSTED) |-> (freed_reg == '0 && addr_reg == '0))
        else $error("exhaustion reported with freed hunks on the stack");

    // A full report comes only from a stack at its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_reg == ST_FULL) |-> (freed_reg == COUNT_W'(FREE_DEPTH)))
        else $error("full reported on a stack below its depth");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Fixed hunk pool allocator testbench
// Streams allocate, free, clear and no-op items into the allocator. A shadow
// copy of the pool works out the reply to each accepted item, and every reply
// that leaves the unit is checked field by field against it.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import fhpa_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RX_HOLD_OFF = 400;

    // One input item and one reply item.
    typedef struct packed {
        op_t         op;
        logic [15:0] hunk_address;
    } pool_request_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] address;
        logic [8:0]  freed_count;
    } pool_reply_t;

    // Clock, reset and the unit's ports.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_HUNK_LENGTH;
    logic [REGION_W-1:0]  cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;     // [15:0] hunk_address
    logic [1:0]           s_tuser = OP_NOP; // [1:0] op
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;          // [15:0] address, [24:16] freed_count
    logic [1:0]           m_tuser;          // [1:0] status

    // Items waiting to be sent and replies still owed by the unit.
    pool_request_t pool_requests[$];
    pool_reply_t   replies_due[$];
    pool_request_t offered;
    int            queued_total = 0;
    int            accepted_total = 0;

    // Shadow copy of the pool.
    logic [HUNK_W-1:0]   shadow_hunk_length = HUNK_RESET;
    logic [REGION_W-1:0] shadow_region = REGION_RESET;
    logic [REGION_W-1:0] shadow_bump = '0;
    logic [15:0]         shadow_stack [FREE_DEPTH];
    int unsigned         shadow_free_count = 0;

    // Traffic shaping.
    int   tx_idle_pct = 35;
    int   rx_idle_pct = 76;
    logic tx_hold = 1'b0;
    logic rx_block_start = 1'b0;
    int   rx_block_left = 0;

    // Bookkeeping.
    int mismatch_count = 0;
    int replies_checked = 0;
    int stack_pops = 0;
    int fresh_hunks = 0;
    int exhausted_hits = 0;
    int full_hits = 0;
    int cycle_count = 0;

    fixed_hunk_pool_allocator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 clk = ~clk;

    // Applies one operation to the shadow pool and returns the reply it owes.
    function automatic pool_reply_t pool_step(input pool_request_t req);
        pool_reply_t reply;
        int unsigned pad;
        int unsigned remaining;
        logic [31:0] next_bump;
        reply.status  = ST_OK;
        reply.address = '0;
        case (req.op)
            OP_ALLOC:
            begin
                if (shadow_free_count > 0)
                begin
                    shadow_free_count--;
                    reply.address = shadow_stack[shadow_free_count];
                    stack_pops++;
                end
                else
                begin
                    pad = (32'(shadow_hunk_length) + 32'd3) & ~32'd3;
                    remaining = (shadow_region > shadow_bump) ?
                                32'(shadow_region) - 32'(shadow_bump) : 0;
                    if (remaining < pad)
                    begin
                        reply.status = ST_EXHAUSTED;
                        exhausted_hits++;
                    end
                    else
                    begin
                        // Offsets past the address width come back masked.
                        reply.address = shadow_bump[15:0];
                        next_bump = shadow_bump + pad;
                        shadow_bump = next_bump[REGION_W-1:0];
                        fresh_hunks++;
                    end
                end
            end
            OP_FREE:
            begin
                // Any offset is taken; a full stack drops it and keeps its state.
                if (shadow_free_count >= FREE_DEPTH)
                begin
                    reply.status = ST_FULL;
                    full_hits++;
                end
                else
                begin
                    shadow_stack[shadow_free_count] = req.hunk_address;
                    shadow_free_count++;
                end
            end
            OP_CLEAR:
            begin
                shadow_free_count = 0;
                shadow_bump = '0;
            end
            default:
            begin
            end
        endcase
        reply.freed_count = shadow_free_count[8:0];
        return reply;
    endfunction

    task automatic queue_op(input op_t op, input logic [15:0] addr);
        pool_request_t req;
        req.op = op;
        req.hunk_address = addr;
        pool_requests.push_back(req);
        queued_total++;
    endtask

    // Waits until every queued item was taken and every reply has come back.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (accepted_total != queued_total || replies_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REGION_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HUNK_LENGTH)
            shadow_hunk_length = value[HUNK_W-1:0];
        else
            shadow_region = value;
    endtask

    // Sets up one pool geometry once the unit has gone quiet.
    task automatic apply_setting(input int sel);
        logic [REGION_W-1:0] hunk_word;
        logic [REGION_W-1:0] region_word;
        int unsigned         pad;
        case (sel)
            0:
            begin
                hunk_word = 17'd1;
                region_word = 17'd100;
            end
            1:
            begin
                hunk_word = 17'd8191;
                region_word = 17'd131071;
            end
            2:
            begin
                hunk_word = 17'd0;
                region_word = 17'd12;
            end
            3:
            begin
                hunk_word = 17'd4096;
                region_word = 17'd65536;
            end
            4:
            begin
                hunk_word = 17'd13;
                region_word = 17'd0;
            end
            5:
            begin
                // Only the low bits of the word reach the hunk length.
                hunk_word = 17'h12005;
                region_word = 17'd131071;
            end
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    hunk_word = 17'($urandom_range(1, 4096));
                    region_word = 17'($urandom_range(0, 131071));
                end
                else
                begin
                    hunk_word = 17'($urandom_range(1, 64));
                    pad = (32'(hunk_word) + 32'd3) & ~32'd3;
                    region_word = 17'(pad * $urandom_range(1, 24) + $urandom_range(0, 3));
                end
            end
        endcase
        wait_idle();
        write_reg(CFG_HUNK_LENGTH, hunk_word);
        write_reg(CFG_REGION_BYTES, region_word);
    endtask

    // Random traffic: mostly runs of allocates and frees, some noise.
    task automatic queue_traffic(input int count);
        int goal;
        int kind;
        int burst;
        goal = queued_total + count;
        while (queued_total < goal)
        begin
            kind = $urandom_range(0, 9);
            burst = $urandom_range(1, 16);
            if (kind < 3)
                repeat (burst) queue_op(OP_ALLOC, 16'($urandom_range(0, 16'hFFFF)));
            else if (kind < 5)
                repeat (burst) queue_op(OP_FREE, 16'($urandom_range(0, 16'hFFFF)));
            else if (kind < 7)
            begin
                repeat (burst)
                begin
                    queue_op(OP_FREE, 16'($urandom_range(0, 16'hFFFF)));
                    queue_op(OP_ALLOC, 16'($urandom_range(0, 16'hFFFF)));
                end
            end
            else if (kind < 9)
                repeat (burst) queue_op(op_t'($urandom_range(0, 3)),
                                        16'($urandom_range(0, 16'hFFFF)));
            else
                queue_op(OP_CLEAR, 16'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    // Holds the sender back until the unit has answered everything it took.
    task automatic pause_sender();
        @(posedge clk);
        tx_hold <= 1'b1;
        do
            @(posedge clk);
        while (s_tvalid || replies_due.size() != 0);
        tx_hold <= 1'b0;
    endtask

    task automatic note_mismatch(input pool_reply_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("Mismatch: want st %0d addr %h cnt %0d, got st %0d addr %h cnt %0d",
                     want.status, want.address, want.freed_count,
                     m_tuser, m_tdata[15:0], m_tdata[24:16]);
    endtask

    // Sender: offers queued items and updates the shadow pool on acceptance.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                replies_due.push_back(pool_step(offered));
                accepted_total++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (!tx_hold && pool_requests.size() != 0 &&
                    $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    offered = pool_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= offered.hunk_address;
                    s_tuser  <= offered.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down here on its own.
    always @(posedge clk)
    begin
        if (rx_block_start)
            rx_block_left <= RX_HOLD_OFF;
        else if (rx_block_left > 0)
            rx_block_left <= rx_block_left - 1;
    end

    // Receiver: takes replies and checks each against the oldest one owed.
    always @(posedge clk)
    begin
        pool_reply_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                replies_checked++;
                if (replies_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected reply: status %0d address %h count %0d",
                                 m_tuser, m_tdata[15:0], m_tdata[24:16]);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (m_tuser != want.status || m_tdata[15:0] != want.address ||
                        m_tdata[24:16] != want.freed_count)
                        note_mismatch(want);
                end
            end
            m_tready <= (rx_block_left == 0) && !rx_block_start &&
                        ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset geometry, empty region, stack order and field extremes.
        queue_op(OP_ALLOC, 16'h0000);
        queue_op(OP_NOP, 16'hFFFF);
        queue_op(OP_FREE, 16'hFFFF);
        queue_op(OP_FREE, 16'h0000);
        queue_op(OP_ALLOC, 16'hFFFF);
        queue_op(OP_ALLOC, 16'h0000);
        queue_op(OP_ALLOC, 16'h0000);

        // Padding of an odd length, running out, then a region shrunk below the bump.
        wait_idle();
        write_reg(CFG_HUNK_LENGTH, 17'd5);
        write_reg(CFG_REGION_BYTES, 17'd20);
        queue_op(OP_ALLOC, 16'h0000);
        queue_op(OP_ALLOC, 16'h0000);
        queue_op(OP_ALLOC, 16'h0000);
        wait_idle();
        write_reg(CFG_REGION_BYTES, 17'd8);
        queue_op(OP_ALLOC, 16'h0000);
        queue_op(OP_FREE, 16'h1234);
        queue_op(OP_CLEAR, 16'hFFFF);
        queue_op(OP_ALLOC, 16'h0000);

        // Zero hunk length hands out the same offset without advancing.
        wait_idle();
        write_reg(CFG_HUNK_LENGTH, 17'd0);
        write_reg(CFG_REGION_BYTES, 17'd0);
        queue_op(OP_ALLOC, 16'h0000);
        queue_op(OP_ALLOC, 16'h0000);

        // Largest length over the largest region.
        wait_idle();
        write_reg(CFG_HUNK_LENGTH, 17'd8191);
        write_reg(CFG_REGION_BYTES, 17'd131071);
        repeat (4) queue_op(OP_ALLOC, 16'h0000);
        queue_op(OP_NOP, 16'h0000);

        // Random part, three settings for each idling mix.
        for (int sel = 0; sel < 9; sel++)
        begin
            if (sel == 3)
            begin
                tx_idle_pct = 76;
                rx_idle_pct = 35;
            end
            else if (sel == 6)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            apply_setting(sel);
            if (sel == 6)
            begin
                // Receiver stalls while the stack is filled past its depth.
                @(posedge clk);
                rx_block_start <= 1'b1;
                @(posedge clk);
                rx_block_start <= 1'b0;
                repeat (FREE_DEPTH + 4) queue_op(OP_FREE, 16'($urandom_range(0, 16'hFFFF)));
                repeat (4) queue_op(OP_ALLOC, 16'($urandom_range(0, 16'hFFFF)));
            end
            queue_traffic(45);
            if (sel == 4)
                pause_sender();
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            mismatch_count++;
            $display("%0d replies never arrived", replies_due.size());
        end

        $display("Covered %0d pool operations, fourteen geometries, three idling mixes.",
                 accepted_total);
        $display("Checked %0d replies: %0d pops, %0d fresh, %0d exhausted, %0d full.",
                 replies_checked, stack_pops, fresh_hunks, exhausted_hits, full_hits);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hdl/fhpa_pkg.sv
hdl/fhpa_stack.sv
hdl/fixed_hunk_pool_allocator_unit.sv
tb/testbench.sv
